FILE: hdl/psgf_pkg.sv
`default_nettype none

package psgf_pkg;

    // Field widths
    localparam int unsigned SEC_W    = 32;
    localparam int unsigned BLK_W    = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned STEP_W   = 16;
    localparam int unsigned WRAP_W   = 24;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned DIV_W    = 32;

    // Default cap on fill results per item
    localparam int unsigned PSGF_MAX_FILLS = 63;

    // A stamp more than this far past the last one is bad time
    localparam logic [SEC_W-1:0] TIME_SLACK = SEC_W'(10);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WRAP = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(16);
    localparam logic [WRAP_W-1:0] WRAP_RESET = WRAP_W'(12207);

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_REAL     = 2'd0,
        KIND_FILL     = 2'd1,
        KIND_BAD_TIME = 2'd2,
        KIND_DUP      = 2'd3
    } t_kind;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_QDIV,
        S_FILL,
        S_FDIV,
        S_REAL
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_fill;
        logic set_lost;
        logic emit_reject;
        logic emit_fill_fast;
        logic emit_fill_slow;
        logic emit_real;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic bad_time;
        logic dup;
        logic no_fills;
        logic div_done;
        logic q_single;
        logic fill_fast;
        logic lost_last;
    } t_sts;

endpackage

`default_nettype wire

FILE: hdl/psgf_if.sv
`default_nettype none

// Header channel
interface psgf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_stamp;
    logic [31:0] block_id;

    modport source (output valid, output seconds_stamp, output block_id, input ready);
    modport sink   (input valid, input seconds_stamp, input block_id, output ready);
endinterface

// Result channel
interface psgf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] out_seconds;
    logic [31:0] out_block;
    logic        last;
    logic        fills_truncated;
    logic [31:0] accepted_total;
    logic [31:0] rejected_total;

    modport source (output valid, output kind, output out_seconds, output out_block,
                    output last, output fills_truncated, output accepted_total,
                    output rejected_total, input ready);
    modport sink   (input valid, input kind, input out_seconds, input out_block,
                    input last, input fills_truncated, input accepted_total,
                    input rejected_total, output ready);
endinterface

`default_nettype wire

FILE: hdl/psgf_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module psgf_div
    import psgf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quotient,
    output logic [DIV_W-1:0]      o_remainder
);

    localparam int unsigned STEP_CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0]      r_rem;
    logic [DIV_W-1:0]      r_quo;
    logic [DIV_W-1:0]      r_dvs;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIV_W:0]        w_shift;
    logic [DIV_W:0]        w_diff;
    logic                  w_ge;

    // One trial subtraction
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == STEP_CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

FILE: hdl/psgf_ctrl.sv
`default_nettype none

// Sequencer: check, reject or divide, fills, real result
module psgf_ctrl
    import psgf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.bad_time || i_sts.dup) begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end else if (i_sts.no_fills) begin
                    n_state = S_REAL;
                end else begin
                    n_state = S_QDIV;
                end
            end
            S_QDIV: begin
                if (i_sts.div_done) n_state = i_sts.q_single ? S_REAL : S_FILL;
            end
            S_FILL: begin
                if (!i_sts.fill_fast) begin
                    n_state = S_FDIV;
                end else if (i_sts.out_free && i_sts.lost_last) begin
                    n_state = S_REAL;
                end
            end
            S_FDIV: begin
                if (i_sts.div_done && i_sts.out_free) begin
                    n_state = i_sts.lost_last ? S_REAL : S_FILL;
                end
            end
            S_REAL: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_CHECK: begin
                if (i_sts.bad_time || i_sts.dup) begin
                    o_cmd.emit_reject = i_sts.out_free;
                end else if (!i_sts.no_fills) begin
                    o_cmd.div_start = 1'b1;
                end
            end
            S_QDIV: begin
                o_cmd.set_lost = i_sts.div_done;
            end
            S_FILL: begin
                if (i_sts.fill_fast) begin
                    o_cmd.emit_fill_fast = i_sts.out_free;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_fill  = 1'b1;
                end
            end
            S_FDIV: begin
                o_cmd.div_fill       = 1'b1;
                o_cmd.emit_fill_slow = i_sts.div_done && i_sts.out_free;
            end
            S_REAL: begin
                o_cmd.emit_real = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/psgf_dp.sv
`default_nettype none

// Position state, counters, config registers, divider and result register
module psgf_dp
    import psgf_pkg::*;
#(
    parameter int unsigned MAX_FILLS = PSGF_MAX_FILLS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    psgf_in_if.sink                    i_in,
    psgf_out_if.source                 o_out,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts
);

    localparam int unsigned LOST_W = $clog2(MAX_FILLS + 1);

    // Config
    logic [STEP_W-1:0] r_step;
    logic [WRAP_W-1:0] r_wrap;

    // Item and position state
    logic [SEC_W-1:0]  r_sec;
    logic [BLK_W-1:0]  r_blk;
    logic [SEC_W-1:0]  r_last_sec;
    logic [BLK_W-1:0]  r_last_blk;
    logic [SEC_W-1:0]  r_start_sec;
    logic              r_any;
    logic [CNT_W-1:0]  r_acc;
    logic [CNT_W-1:0]  r_rej;
    logic [LOST_W-1:0] r_lost;
    logic              r_trunc;

    // Result register
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [SEC_W-1:0]  r_out_sec;
    logic [BLK_W-1:0]  r_out_blk;
    logic              r_out_last;
    logic              r_out_trunc;
    logic [CNT_W-1:0]  r_out_acc;
    logic [CNT_W-1:0]  r_out_rej;

    logic [BLK_W-1:0]  w_step_x;
    logic [BLK_W-1:0]  w_wrap_x;
    logic [BLK_W-1:0]  w_diff;
    logic [BLK_W-1:0]  w_nb;
    logic [BLK_W-1:0]  w_nb_sub;
    logic              w_carry;
    logic              w_wrap_zero;
    logic [BLK_W-1:0]  w_fast_blk;
    logic [SEC_W-1:0]  w_fill_sec;
    logic              w_out_free;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quo;
    logic [DIV_W-1:0]  w_rem;
    logic [DIV_W-1:0]  w_dividend;
    logic [DIV_W-1:0]  w_divisor;
    logic              w_q_over;

    assign w_step_x    = BLK_W'(r_step);
    assign w_wrap_x    = BLK_W'(r_wrap);
    assign w_wrap_zero = (r_wrap == '0);
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Wrapped block distance
    assign w_diff = (r_blk >= r_last_blk) ? (r_blk - r_last_blk)
                                          : (r_blk + w_wrap_x - r_last_blk);

    // Next fill position; a full modulo only when the sum is at least twice the wrap
    assign w_nb       = r_last_blk + w_step_x;
    assign w_carry    = (w_nb >= w_wrap_x);
    assign w_nb_sub   = w_nb - w_wrap_x;
    assign w_fast_blk = (w_wrap_zero || !w_carry) ? w_nb : w_nb_sub;
    assign w_fill_sec = r_last_sec + SEC_W'(w_carry);

    // Divider shared by quotient and fill modulo
    assign w_dividend = i_cmd.div_fill ? w_nb : w_diff;
    assign w_divisor  = i_cmd.div_fill ? w_wrap_x : w_step_x;
    assign w_q_over   = (w_quo > DIV_W'(MAX_FILLS + 1));

    psgf_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Status
    always_comb begin
        o_sts.out_free  = w_out_free;
        o_sts.bad_time  = (r_sec == '1) || ((r_last_sec + TIME_SLACK) < r_sec);
        o_sts.dup       = (w_diff < w_step_x);
        o_sts.no_fills  = (r_step == '0) || (w_diff <= w_step_x);
        o_sts.div_done  = w_div_done;
        o_sts.q_single  = (w_quo == DIV_W'(1));
        o_sts.fill_fast = w_wrap_zero || !w_carry || (w_nb_sub < w_wrap_x);
        o_sts.lost_last = (r_lost == LOST_W'(1));
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_wrap <= WRAP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_BLOCK_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                REG_BLOCK_WRAP: r_wrap <= i_cfg_data[WRAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Latched header
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sec <= i_in.seconds_stamp;
            r_blk <= i_in.block_id;
        end
    end

    // Position state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sec  <= '0;
            r_last_blk  <= '0;
            r_start_sec <= '0;
            r_any       <= 1'b0;
            r_acc       <= '0;
            r_rej       <= '0;
            r_lost      <= '0;
            r_trunc     <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_trunc <= 1'b0;
                // reference taken from the header while nothing is accepted and the start stamp is zero
                if (!r_any && (r_start_sec == '0)) begin
                    r_start_sec <= i_in.seconds_stamp;
                    r_last_sec  <= i_in.seconds_stamp;
                    r_last_blk  <= i_in.block_id;
                end
            end
            if (i_cmd.set_lost) begin
                r_trunc <= w_q_over;
                r_lost  <= w_q_over ? LOST_W'(MAX_FILLS) : LOST_W'(w_quo - DIV_W'(1));
            end
            if (i_cmd.emit_fill_fast) begin
                r_last_sec <= w_fill_sec;
                r_last_blk <= w_fast_blk;
                r_lost     <= r_lost - 1'b1;
            end
            if (i_cmd.emit_fill_slow) begin
                r_last_sec <= w_fill_sec;
                r_last_blk <= w_rem;
                r_lost     <= r_lost - 1'b1;
            end
            if (i_cmd.emit_reject) r_rej <= r_rej + 1'b1;
            if (i_cmd.emit_real) begin
                r_acc      <= r_acc + 1'b1;
                r_any      <= 1'b1;
                r_last_sec <= r_sec;
                r_last_blk <= r_blk;
            end
        end
    end

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_reject || i_cmd.emit_fill_fast ||
                     i_cmd.emit_fill_slow || i_cmd.emit_real) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.emit_reject) begin
            r_out_kind  <= o_sts.bad_time ? KIND_BAD_TIME : KIND_DUP;
            r_out_sec   <= r_sec;
            r_out_blk   <= r_blk;
            r_out_last  <= 1'b1;
            r_out_trunc <= 1'b0;
            r_out_acc   <= r_acc;
            r_out_rej   <= r_rej + 1'b1;
        end else if (i_cmd.emit_fill_fast || i_cmd.emit_fill_slow) begin
            r_out_kind  <= KIND_FILL;
            r_out_sec   <= w_fill_sec;
            r_out_blk   <= i_cmd.emit_fill_slow ? w_rem : w_fast_blk;
            r_out_last  <= 1'b0;
            r_out_trunc <= r_trunc;
            r_out_acc   <= r_acc;
            r_out_rej   <= r_rej;
        end else if (i_cmd.emit_real) begin
            r_out_kind  <= KIND_REAL;
            r_out_sec   <= r_sec;
            r_out_blk   <= r_blk;
            r_out_last  <= 1'b1;
            r_out_trunc <= r_trunc;
            r_out_acc   <= r_acc + 1'b1;
            r_out_rej   <= r_rej;
        end else begin
            r_out_kind  <= r_out_kind;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out_kind;
    assign o_out.out_seconds     = r_out_sec;
    assign o_out.out_block       = r_out_blk;
    assign o_out.last            = r_out_last;
    assign o_out.fills_truncated = r_out_trunc;
    assign o_out.accepted_total  = r_out_acc;
    assign o_out.rejected_total  = r_out_rej;

    // Fill results never close an item
    a_fill_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_FILL)) |-> !r_out_last)
        else $error("fill result marked last");

    // Rejections carry no truncation flag and close the item
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_kind == KIND_BAD_TIME) || (r_out_kind == KIND_DUP)))
        |-> (!r_out_trunc && r_out_last))
        else $error("rejection with truncation or not last");

    // A fill is only emitted while fills remain
    a_fill_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_fill_fast || i_cmd.emit_fill_slow) |-> (r_lost != '0))
        else $error("fill emitted with no lost packets left");

    // A new item starts with the truncation flag clear
    a_load_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_in |=> (r_trunc == 1'b0))
        else $error("truncation flag survived a new item");

endmodule

`default_nettype wire

FILE: hdl/packet_sequence_gap_filler.sv
`default_nettype none

// Packet sequence gap filler. Each input item is a packet header (seconds stamp,
// block id); each result is one of: a fill for a lost packet, the real packet, or a
// rejection (bad time or duplicate), with running accepted/rejected counts. The first
// header taken while nothing has been accepted and the start stamp is zero sets the
// reference; it is reported as a duplicate, as bad time if its stamp is all ones, or
// as real if block_step is zero. Timing: a header is taken, then checked in the next
// cycle; a rejection is registered once the output register is free. An accepted
// header runs the wrapped block distance through a shared 32-step restoring divider
// unless the distance is at most one step or block_step is zero; each fill is then
// formed directly, or by the same divider as a modulo when the advanced block is at
// least twice block_wrap; the real packet follows. One header is in work at a time;
// the next may be taken while the last result still waits in the output register.
// Configuration writes take effect at once and belong only to idle periods.
module packet_sequence_gap_filler
    import psgf_pkg::*;
#(
    parameter int unsigned MAX_FILLS = PSGF_MAX_FILLS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    psgf_in_if.sink                    i_in,
    psgf_out_if.source                 o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer
    psgf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    psgf_dp #(
        .MAX_FILLS (MAX_FILLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

`default_nettype wire

FILE: verif/tb_packet_sequence_gap_filler.sv
`timescale 1ns / 100ps

module tb_packet_sequence_gap_filler
    import psgf_pkg::*;
();

    localparam int unsigned QUIET_LIMIT = 4000;  // cycles with no handshake at all
    localparam int unsigned HOLD_CYCLES = 400;   // long receiver back-pressure
    localparam int unsigned PHASE_ITEMS = 18;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned SETTLE      = 40;    // settle wait after the last result

    // One emitted or rejected packet
    typedef struct {
        t_kind       kind;
        logic [31:0] sec;
        logic [31:0] blk;
        logic        last;
        logic        trunc;
        logic [31:0] good;
        logic [31:0] drop;
    } t_pkt_res;

    // Directed stimulus row: a register write or a header, with an optional
    // hand-typed single result
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [31:0]           sec;
        logic [31:0]           blk;
        bit                    typed;
        t_kind                 kind;
        logic [31:0]           good;
        logic [31:0]           drop;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    psgf_in_if  hdr_if ();
    psgf_out_if res_if ();

    packet_sequence_gap_filler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in        (hdr_if),
        .o_out       (res_if)
    );

    // Shadow of the block's registers and sequence state
    logic [STEP_W-1:0] cur_step;
    logic [WRAP_W-1:0] cur_wrap;
    logic [31:0]       prev_sec;
    logic [31:0]       prev_blk;
    logic [31:0]       anchor_sec;
    logic              seen_good;
    logic [31:0]       good_cnt;
    logic [31:0]       drop_cnt;

    t_pkt_res    pending_pkts [$];
    int unsigned mismatch_cnt;
    int unsigned quiet_cycles;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          hold_req;

    // Rejections come first in each row's check; counts are known at a glance
    t_dir_row dir_tbl [0:24] = '{
        '{0, REG_BLOCK_STEP, 24'h0, 32'h0000_0000, 32'h0000_0000, 1, KIND_DUP,      0, 1},
        '{0, REG_BLOCK_STEP, 24'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, KIND_BAD_TIME, 0, 2},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd3,         32'd0,         0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd14,        32'd16,        1, KIND_BAD_TIME, 1, 3},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd13,        32'd16,        0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd13,        32'd16,        1, KIND_DUP,      2, 4},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd13,        32'd20,        0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd13,        32'd96,        0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd13,        32'd12200,     0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd14,        32'd40,        0, KIND_REAL,     0, 0},
        '{1, REG_BLOCK_STEP, 24'h0, 32'd0,         32'd0,         0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd15,        32'd40,        0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd15,        32'd7,         0, KIND_REAL,     0, 0},
        '{1, REG_BLOCK_STEP, 24'hFF03E8, 32'd0,    32'd0,         0, KIND_REAL,     0, 0},
        '{1, REG_BLOCK_WRAP, 24'h0, 32'd0,         32'd0,         0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd15,        32'd5000,      0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd15,        32'd3,         0, KIND_REAL,     0, 0},
        '{1, REG_BLOCK_STEP, 24'h00FFFF, 32'd0,    32'd0,         0, KIND_REAL,     0, 0},
        '{1, REG_BLOCK_WRAP, 24'hFFFFFF, 32'd0,    32'd0,         0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd25,        32'd131073,    0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd25,        32'hFFFF_FFFE, 0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd26,        32'd100,       0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd26,        32'h8000_0000, 0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd27,        32'h8002_FFFD, 0, KIND_REAL,     0, 0},
        '{0, REG_BLOCK_STEP, 24'h0, 32'd27,        32'h7FFF_FFFF, 0, KIND_REAL,     0, 0}
    };

    // Register settings per random phase; the last one is drawn at run time
    logic [CFG_DATA_W-1:0] step_set [0:NUM_PHASES-1] = '{
        24'd16, 24'd1, 24'd65535, 24'd3, 24'd0, 24'd7, 24'd1, 24'd0
    };
    logic [CFG_DATA_W-1:0] wrap_set [0:NUM_PHASES-1] = '{
        24'd12207, 24'hFFFFFF, 24'hFFFFFF, 24'd50, 24'd1000, 24'd0, 24'd1, 24'd0
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Queue one result with the running counts
    function automatic void push_pkt(input t_kind k, input logic [31:0] s,
                                     input logic [31:0] b, input logic fin,
                                     input logic tr);
        t_pkt_res r;
        r.kind  = k;
        r.sec   = s;
        r.blk   = b;
        r.last  = fin;
        r.trunc = tr;
        r.good  = good_cnt;
        r.drop  = drop_cnt;
        pending_pkts.push_back(r);
    endfunction

    // Gap detection and fill for one accepted header
    function automatic void track_header(input logic [31:0] s, input logic [31:0] b);
        logic [31:0] wrap32;
        logic [31:0] step32;
        logic [31:0] blk_gap;
        logic [31:0] lost;
        logic [31:0] nxt;
        logic        tr;
        wrap32 = 32'(cur_wrap);
        step32 = 32'(cur_step);

        // reference is (re)taken while nothing is accepted and the anchor stamp is zero
        if (!seen_good && anchor_sec == 32'd0) begin
            anchor_sec = s;
            prev_sec   = s;
            prev_blk   = b;
        end

        if (s == 32'hFFFF_FFFF || (prev_sec + TIME_SLACK) < s) begin
            drop_cnt++;
            push_pkt(KIND_BAD_TIME, s, b, 1'b1, 1'b0);
            return;
        end

        if (b >= prev_blk)
            blk_gap = b - prev_blk;
        else
            blk_gap = b + wrap32 - prev_blk;

        if (blk_gap < step32) begin
            drop_cnt++;
            push_pkt(KIND_DUP, s, b, 1'b1, 1'b0);
            return;
        end

        lost = 32'd0;
        if (step32 != 32'd0 && blk_gap > step32)
            lost = blk_gap / step32 - 32'd1;
        tr = 1'b0;
        if (lost > PSGF_MAX_FILLS) begin
            lost = PSGF_MAX_FILLS;
            tr   = 1'b1;
        end

        // fills advance by one step each, carrying into seconds at the wrap
        for (int unsigned i = 0; i < lost; i++) begin
            nxt = prev_blk + step32;
            if (!(nxt < wrap32))
                prev_sec++;
            prev_blk = (wrap32 != 32'd0) ? (nxt % wrap32) : nxt;
            push_pkt(KIND_FILL, prev_sec, prev_blk, 1'b0, tr);
        end

        good_cnt++;
        seen_good = 1'b1;
        prev_sec  = s;
        prev_blk  = b;
        push_pkt(KIND_REAL, s, b, 1'b1, tr);
    endfunction

    // Offer one header, record its results once taken
    task automatic send_hdr(input logic [31:0] s, input logic [31:0] b,
                            input bit typed, input t_pkt_res typed_res);
        while ($urandom_range(99) < src_idle_pct) begin
            hdr_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        hdr_if.valid         <= 1'b1;
        hdr_if.seconds_stamp <= s;
        hdr_if.block_id      <= b;
        @(posedge i_clk);
        while (!hdr_if.ready) @(posedge i_clk);
        track_header(s, b);
        // hand-typed rows cause exactly one result
        if (typed)
            pending_pkts[pending_pkts.size() - 1] = typed_res;
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every pending result, then let the block settle
    task automatic drain(input int unsigned extra);
        hdr_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_pkts.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_BLOCK_STEP)
            cur_step = val[STEP_W-1:0];
        else
            cur_wrap = val[WRAP_W-1:0];
        @(negedge i_clk);
    endtask

    // Mostly in-sequence headers, plus duplicates, bad stamps and noise
    task automatic send_random();
        t_pkt_res    unused;
        logic [63:0] ahead;
        logic [31:0] s;
        logic [31:0] b;
        int unsigned pick;
        int unsigned k;
        unused = '{KIND_REAL, 0, 0, 0, 0, 0, 0};
        pick = $urandom_range(99);
        if (pick < 72) begin
            // next packet after a short gap, sometimes a long one
            k = ($urandom_range(9) == 0) ? $urandom_range(80, 62) : $urandom_range(4, 1);
            ahead = 64'(prev_blk) + 64'(cur_step) * 64'(k);
            b = (cur_wrap != '0) ? 32'(ahead % 64'(cur_wrap)) : ahead[31:0];
            s = prev_sec + $urandom_range(2, 0);
        end else if (pick < 80) begin
            // repeat of the last packet or within one step of it
            s = prev_sec;
            b = prev_blk + ((cur_step > 1) ? $urandom_range(32'(cur_step) - 1, 0) : 0);
        end else if (pick < 88) begin
            s = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : prev_sec + $urandom_range(5000, 11);
            b = prev_blk + 32'(cur_step);
        end else if (pick < 94) begin
            // random block id, often outside the wrap
            s = prev_sec;
            b = $urandom;
        end else begin
            s = $urandom;
            b = $urandom;
        end
        send_hdr(s, b, 1'b0, unused);
    endtask

    // Receiver: random ready, with one long hold on request
    initial begin : sink_drive
        int unsigned hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Result checker and watchdog
    always @(posedge i_clk) begin : res_check
        t_pkt_res want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (pending_pkts.size() == 0) begin
                    $error("result with nothing pending: kind %0d sec %0h blk %0h",
                           res_if.kind, res_if.out_seconds, res_if.out_block);
                    mismatch_cnt++;
                end else begin
                    want = pending_pkts.pop_front();
                    if (res_if.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
                        mismatch_cnt++;
                    end
                    if (res_if.out_seconds !== want.sec) begin
                        $error("out_seconds: expected %0h, got %0h",
                               want.sec, res_if.out_seconds);
                        mismatch_cnt++;
                    end
                    if (res_if.out_block !== want.blk) begin
                        $error("out_block: expected %0h, got %0h", want.blk, res_if.out_block);
                        mismatch_cnt++;
                    end
                    if (res_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, res_if.last);
                        mismatch_cnt++;
                    end
                    if (res_if.fills_truncated !== want.trunc) begin
                        $error("fills_truncated: expected %0d, got %0d",
                               want.trunc, res_if.fills_truncated);
                        mismatch_cnt++;
                    end
                    if (res_if.accepted_total !== want.good) begin
                        $error("accepted_total: expected %0d, got %0d",
                               want.good, res_if.accepted_total);
                        mismatch_cnt++;
                    end
                    if (res_if.rejected_total !== want.drop) begin
                        $error("rejected_total: expected %0d, got %0d",
                               want.drop, res_if.rejected_total);
                        mismatch_cnt++;
                    end
                end
            end

            if ((res_if.valid && res_if.ready) || (hdr_if.valid && hdr_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("no item moved for %0d cycles, %0d results pending",
                       quiet_cycles, pending_pkts.size());
                $display("tb_packet_sequence_gap_filler NOT OK");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin : stim
        t_pkt_res              typed_res;
        logic [CFG_DATA_W-1:0] step_val;
        logic [CFG_DATA_W-1:0] wrap_val;
        mismatch_cnt = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        src_idle_pct = 13;
        snk_idle_pct = 46;
        cur_step     = STEP_RESET;
        cur_wrap     = WRAP_RESET;
        prev_sec     = '0;
        prev_blk     = '0;
        anchor_sec   = '0;
        seen_good    = 1'b0;
        good_cnt     = '0;
        drop_cnt     = '0;

        i_rst_n              <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_idx              <= REG_BLOCK_STEP;
        cfg_data             <= '0;
        hdr_if.valid         <= 1'b0;
        hdr_if.seconds_stamp <= '0;
        hdr_if.block_id      <= '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reference setup, boundaries, both zero-register cases
        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].is_cfg) begin
                drain(SETTLE);
                write_reg(dir_tbl[i].reg_idx, dir_tbl[i].reg_val);
            end else begin
                typed_res = '{dir_tbl[i].kind, dir_tbl[i].sec, dir_tbl[i].blk, 1'b1, 1'b0,
                              dir_tbl[i].good, dir_tbl[i].drop};
                send_hdr(dir_tbl[i].sec, dir_tbl[i].blk, dir_tbl[i].typed, typed_res);
            end
        end

        // Random part, one register setting per phase
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            if (p < 3) begin
                src_idle_pct = 13;
                snk_idle_pct = 46;
            end else if (p < 6) begin
                src_idle_pct = 46;
                snk_idle_pct = 13;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            step_val = step_set[p];
            wrap_val = wrap_set[p];
            if (p == NUM_PHASES - 1) begin
                step_val = CFG_DATA_W'($urandom_range(300, 1));
                wrap_val = CFG_DATA_W'($urandom_range(100000, 1));
            end
            // upper data bits above the step field are don't-care
            step_val[CFG_DATA_W-1:STEP_W] = 8'($urandom);
            drain(SETTLE);
            write_reg(REG_BLOCK_STEP, step_val);
            write_reg(REG_BLOCK_WRAP, wrap_val);

            for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == 4)
                    hold_req = 1'b1;
                if (p == 2 && n == 10)
                    drain(0);
                send_random();
            end
        end

        drain(SETTLE);
        if (mismatch_cnt == 0)
            $display("tb_packet_sequence_gap_filler OK");
        else
            $display("tb_packet_sequence_gap_filler NOT OK");
        $finish;
    end

endmodule
